[design/smc_pkg.sv]
// ----------------------------------------------------------------------------
// smc_pkg
// Shared constants, codes, types and helper functions of the simple machine
// core: memory geometry, operation modes, opcodes, error codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package smc_pkg;

	// Byte memory size; must be a power of two so that addresses wrap by masking.
	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NUM_REGS  = 8;
	localparam int REG_AW    = $clog2(NUM_REGS);

	// Operation modes carried with each input item.
	localparam logic [2:0] MODE_WRITE_BYTE = 3'd0;
	localparam logic [2:0] MODE_READ_BYTE  = 3'd1;
	localparam logic [2:0] MODE_READ_REG   = 3'd2;
	localparam logic [2:0] MODE_RESTART    = 3'd3;
	localparam logic [2:0] MODE_STEP       = 3'd4;

	// Instruction opcodes.
	localparam logic [3:0] OP_LD_IMM   = 4'h0;
	localparam logic [3:0] OP_LD_OFF   = 4'h1;
	localparam logic [3:0] OP_LD_IDX   = 4'h2;
	localparam logic [3:0] OP_ST_OFF   = 4'h3;
	localparam logic [3:0] OP_ST_IDX   = 4'h4;
	localparam logic [3:0] OP_ALU      = 4'h6;
	localparam logic [3:0] OP_SHIFT    = 4'h7;
	localparam logic [3:0] OP_BR       = 4'h8;
	localparam logic [3:0] OP_BEQ      = 4'h9;
	localparam logic [3:0] OP_BGT      = 4'ha;
	localparam logic [3:0] OP_J_IMM    = 4'hb;
	localparam logic [3:0] OP_J_REG    = 4'hc;
	localparam logic [3:0] OP_J_IND    = 4'hd;
	localparam logic [3:0] OP_J_IDX    = 4'he;
	localparam logic [3:0] OP_HALT_NOP = 4'hf;

	// ALU function codes.
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_ADD  = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_INC  = 4'h3;
	localparam logic [3:0] ALU_INC4 = 4'h4;
	localparam logic [3:0] ALU_DEC  = 4'h5;
	localparam logic [3:0] ALU_DEC4 = 4'h6;
	localparam logic [3:0] ALU_NOT  = 4'h7;
	localparam logic [3:0] ALU_GPC  = 4'hf;

	// Error codes reported with each result.
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OPC  = 2'd1;
	localparam logic [1:0] ERR_ALU  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       start;      // latch the input item, clear read value and error
		logic       wr_byte;    // write the input byte at the address register
		logic       wr_word;    // write one byte of operand 0 at address + offset
		logic       rd_issue;   // issue a memory read at address + offset
		logic       shift_in;   // shift the returned byte into the word register
		logic [1:0] off;        // byte offset within a burst
		logic       cap_rbyte;  // read value takes the returned byte
		logic       rd_reg;     // read value takes the selected register
		logic       restart;    // pc from start_pc, clear halt
		logic       addr_pc;    // address register takes pc
		logic       ir_load;    // instruction register takes the fetched halfword
		logic       ext_load;   // extension register takes the fetched word
		logic       reg_load;   // load operand register picked by off
		logic       addr_calc;  // compute the effective data address
		logic       wb;         // execute and write back
		logic       out_load;   // load the output register
	} smc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       halted;
		logic [3:0] opc;        // opcode in the instruction register
		logic [3:0] word_opc;   // opcode in the freshly fetched halfword
	} smc_stat_t;

	// Signed byte offset times two, extended to 32 bits.
	function automatic logic [31:0] sign_off(input logic [7:0] imm);
		sign_off = {{23{imm[7]}}, imm, 1'b0};
	endfunction

	// Left shift for positive immediates, arithmetic right shift otherwise.
	function automatic logic [31:0] shift_op(input logic [31:0] v, input logic [7:0] imm);
		logic [7:0] n;
		n = 8'd0 - imm;
		if (imm != 8'd0 && !imm[7]) begin
			shift_op = (imm >= 8'd32) ? 32'd0 : (v << imm[4:0]);
		end else if (n >= 8'd32) begin
			shift_op = {32{v[31]}};
		end else begin
			shift_op = 32'($signed(v) >>> n[4:0]);
		end
	endfunction

endpackage

[design/smc_ram.sv]
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-port RAM with one registered read.
// ----------------------------------------------------------------------------
module smc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle; read data appears on the next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[design/smc_dp.sv]
// ----------------------------------------------------------------------------
// smc_dp
// Datapath of the simple machine core: register file, pc, halt flag,
// instruction and operand registers, byte memory port and output register.
// ----------------------------------------------------------------------------
module smc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smc_pkg::smc_cmd_t    cmd,
	output smc_pkg::smc_stat_t   stat,
	input  logic [15:0]          in_mem_address,
	input  logic [7:0]           in_write_byte,
	input  logic [2:0]           in_reg_select,
	input  logic                 cfg_valid,
	input  logic [15:0]          cfg_data,
	output logic [66:0]          out_data
);

	logic [31:0] rf_q [smc_pkg::NUM_REGS];
	logic [31:0] opr_q [3];
	logic [31:0] pc_q;
	logic        halt_q;
	logic [15:0] start_pc_q;
	logic [31:0] addr_q;
	logic [31:0] word_q;
	logic [31:0] ext_q;
	logic [15:0] ir_q;
	logic [7:0]  wbyte_q;
	logic [2:0]  rsel_q;
	logic [31:0] rv_q;
	logic [1:0]  err_q;
	logic [66:0] out_q;

	logic [31:0]               addr_sum;
	logic [smc_pkg::MEM_AW-1:0] mem_addr;
	logic [7:0]                mem_wdata;
	logic [7:0]                mem_rdata;
	logic [smc_pkg::REG_AW-1:0] rf_idx;
	logic [31:0]               rf_rdata;
	logic [3:0]                opc, f0, f1, f2;
	logic [7:0]                b1;
	logic [31:0]               r0, r1, r2;
	logic [31:0]               ea;

	assign opc = ir_q[15:12];
	assign f0  = ir_q[11:8];
	assign f1  = ir_q[7:4];
	assign f2  = ir_q[3:0];
	assign b1  = ir_q[7:0];
	assign r0  = opr_q[0];
	assign r1  = opr_q[1];
	assign r2  = opr_q[2];

	assign stat.halted   = halt_q;
	assign stat.opc      = opc;
	assign stat.word_opc = word_q[15:12];

	// Byte address within a burst, wrapped to the memory size.
	assign addr_sum = addr_q + {30'd0, cmd.off};
	assign mem_addr = addr_sum[smc_pkg::MEM_AW-1:0];

	// Store data: the input byte, or operand 0 most significant byte first.
	always_comb begin
		if (cmd.wr_byte) begin
			mem_wdata = wbyte_q;
		end else begin
			case (cmd.off)
				2'd0:    mem_wdata = r0[31:24];
				2'd1:    mem_wdata = r0[23:16];
				2'd2:    mem_wdata = r0[15:8];
				default: mem_wdata = r0[7:0];
			endcase
		end
	end

	smc_ram #(
		.WIDTH(8),
		.DEPTH(smc_pkg::MEM_BYTES)
	) u_mem (
		.clk  (clk),
		.en   (cmd.rd_issue | cmd.wr_byte | cmd.wr_word),
		.we   (cmd.wr_byte | cmd.wr_word),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Single register file read port.
	always_comb begin
		case (cmd.off)
			2'd0:    rf_idx = f0[2:0];
			2'd1:    rf_idx = f1[2:0];
			default: rf_idx = f2[2:0];
		endcase
		if (cmd.rd_reg) begin
			rf_idx = rsel_q;
		end
	end
	assign rf_rdata = rf_q[rf_idx];

	// Effective data address of loads, stores and indirect jumps.
	always_comb begin
		case (opc)
			smc_pkg::OP_LD_OFF: ea = {26'd0, f0, 2'b00} + r1;
			smc_pkg::OP_LD_IDX: ea = r0 + (r1 << 2);
			smc_pkg::OP_ST_OFF: ea = {26'd0, f1, 2'b00} + r2;
			smc_pkg::OP_ST_IDX: ea = r1 + (r2 << 2);
			smc_pkg::OP_J_IND:  ea = r0 + {22'd0, b1, 2'b00};
			smc_pkg::OP_J_IDX:  ea = r0 + (r1 << 2);
			default:            ea = addr_q;
		endcase
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q  <= {16'd0, in_mem_address};
			wbyte_q <= in_write_byte;
			rsel_q  <= in_reg_select;
		end
		if (cmd.addr_pc) begin
			addr_q <= pc_q;
		end
		if (cmd.ir_load) begin
			addr_q <= pc_q + 32'd2;
		end
		if (cmd.addr_calc) begin
			addr_q <= ea;
		end
		if (cmd.shift_in) begin
			word_q <= {word_q[23:0], mem_rdata};
		end
		if (cmd.ir_load) begin
			ir_q <= word_q[15:0];
		end
		if (cmd.ext_load) begin
			ext_q <= word_q;
		end
		if (cmd.reg_load) begin
			opr_q[cmd.off] <= rf_rdata;
		end
		if (cmd.out_load) begin
			out_q <= {err_q, halt_q, pc_q, rv_q};
		end
	end

	// Architectural state, read value and error code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < smc_pkg::NUM_REGS; i++) begin
				rf_q[i] <= 32'd0;
			end
			pc_q       <= 32'd0;
			halt_q     <= 1'b0;
			start_pc_q <= 16'd0;
			rv_q       <= 32'd0;
			err_q      <= smc_pkg::ERR_NONE;
		end else begin
			if (cfg_valid) begin
				start_pc_q <= cfg_data;
			end
			if (cmd.start) begin
				rv_q  <= 32'd0;
				err_q <= smc_pkg::ERR_NONE;
			end
			if (cmd.cap_rbyte) begin
				rv_q <= {24'd0, mem_rdata};
			end
			if (cmd.rd_reg) begin
				rv_q <= rf_rdata;
			end
			if (cmd.restart) begin
				pc_q   <= {16'd0, start_pc_q};
				halt_q <= 1'b0;
			end
			if (cmd.ir_load) begin
				pc_q <= pc_q + 32'd2;
			end
			if (cmd.ext_load) begin
				pc_q <= pc_q + 32'd4;
			end
			// Execute one instruction.
			if (cmd.wb) begin
				case (opc)
					smc_pkg::OP_LD_IMM: rf_q[f0[2:0]] <= ext_q;
					smc_pkg::OP_LD_OFF,
					smc_pkg::OP_LD_IDX: rf_q[f2[2:0]] <= word_q;
					smc_pkg::OP_ST_OFF,
					smc_pkg::OP_ST_IDX: ;
					smc_pkg::OP_ALU: begin
						case (f0)
							smc_pkg::ALU_MOV:  rf_q[f2[2:0]] <= r1;
							smc_pkg::ALU_ADD:  rf_q[f2[2:0]] <= r1 + r2;
							smc_pkg::ALU_AND:  rf_q[f2[2:0]] <= r1 & r2;
							smc_pkg::ALU_INC:  rf_q[f2[2:0]] <= r2 + 32'd1;
							smc_pkg::ALU_INC4: rf_q[f2[2:0]] <= r2 + 32'd4;
							smc_pkg::ALU_DEC:  rf_q[f2[2:0]] <= r2 - 32'd1;
							smc_pkg::ALU_DEC4: rf_q[f2[2:0]] <= r2 - 32'd4;
							smc_pkg::ALU_NOT:  rf_q[f2[2:0]] <= ~r2;
							smc_pkg::ALU_GPC:  rf_q[f2[2:0]] <= pc_q + {27'd0, f1, 1'b0};
							default:           err_q <= smc_pkg::ERR_ALU;
						endcase
					end
					smc_pkg::OP_SHIFT: rf_q[f0[2:0]] <= smc_pkg::shift_op(r0, b1);
					smc_pkg::OP_BR:    pc_q <= pc_q + smc_pkg::sign_off(b1);
					smc_pkg::OP_BEQ: begin
						if (r0 == 32'd0) begin
							pc_q <= pc_q + smc_pkg::sign_off(b1);
						end
					end
					smc_pkg::OP_BGT: begin
						if (r0 != 32'd0 && !r0[31]) begin
							pc_q <= pc_q + smc_pkg::sign_off(b1);
						end
					end
					smc_pkg::OP_J_IMM: pc_q <= ext_q;
					smc_pkg::OP_J_REG: pc_q <= {23'd0, b1, 1'b0} + r0;
					smc_pkg::OP_J_IND,
					smc_pkg::OP_J_IDX: pc_q <= word_q;
					smc_pkg::OP_HALT_NOP: begin
						if (f0 == 4'd0) begin
							halt_q <= 1'b1;
						end
					end
					default: err_q <= smc_pkg::ERR_OPC;
				endcase
			end
		end
	end

	assign out_data = out_q;

endmodule

[design/smc_ctrl.sv]
// ----------------------------------------------------------------------------
// smc_ctrl
// Controller of the simple machine core: sequences each step operation through
// fetch, operand read, address, memory burst where needed and write-back steps,
// runs the other operations directly, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module smc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2:0]          in_mode,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  smc_pkg::smc_stat_t  stat,
	output smc_pkg::smc_cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_WRB, ST_RDB, ST_RDB2, ST_RREG, ST_RST, ST_STEP, ST_FETCH,
		ST_IR, ST_EXT, ST_EXTL, ST_REGS, ST_ADDR, ST_MRD, ST_MWR, ST_WB, ST_FIN
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       m_tvalid_q;
	logic       accept;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// Commands decoded from the state and burst counter.
	always_comb begin
		cmd = '0;
		cmd.off = cnt_q[1:0];
		case (state_q)
			ST_IDLE:  cmd.start = accept;
			ST_WRB:   cmd.wr_byte = 1'b1;
			ST_RDB:   cmd.rd_issue = 1'b1;
			ST_RDB2:  cmd.cap_rbyte = 1'b1;
			ST_RREG:  cmd.rd_reg = 1'b1;
			ST_RST:   cmd.restart = 1'b1;
			ST_STEP:  cmd.addr_pc = !stat.halted;
			ST_FETCH: begin
				cmd.rd_issue = (cnt_q < 3'd2);
				cmd.shift_in = (cnt_q != 3'd0);
			end
			ST_IR:    cmd.ir_load = 1'b1;
			ST_EXT,
			ST_MRD: begin
				cmd.rd_issue = (cnt_q < 3'd4);
				cmd.shift_in = (cnt_q != 3'd0);
			end
			ST_EXTL:  cmd.ext_load = 1'b1;
			ST_REGS:  cmd.reg_load = 1'b1;
			ST_ADDR:  cmd.addr_calc = 1'b1;
			ST_MWR:   cmd.wr_word = 1'b1;
			ST_WB:    cmd.wb = 1'b1;
			ST_FIN:   cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	// State, burst counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result is presented as soon as the old one has gone.
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 3'd0;
					if (accept) begin
						case (in_mode)
							smc_pkg::MODE_WRITE_BYTE: state_q <= ST_WRB;
							smc_pkg::MODE_READ_BYTE:  state_q <= ST_RDB;
							smc_pkg::MODE_READ_REG:   state_q <= ST_RREG;
							smc_pkg::MODE_RESTART:    state_q <= ST_RST;
							smc_pkg::MODE_STEP:       state_q <= ST_STEP;
							default:                  state_q <= ST_FIN;
						endcase
					end
				end
				ST_WRB:  state_q <= ST_FIN;
				ST_RDB:  state_q <= ST_RDB2;
				ST_RDB2: state_q <= ST_FIN;
				ST_RREG: state_q <= ST_FIN;
				ST_RST:  state_q <= ST_FIN;
				ST_STEP: state_q <= stat.halted ? ST_FIN : ST_FETCH;
				ST_FETCH: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= 3'd0;
						state_q <= ST_IR;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_IR: begin
					if (stat.word_opc == smc_pkg::OP_LD_IMM ||
						stat.word_opc == smc_pkg::OP_J_IMM) begin
						state_q <= ST_EXT;
					end else begin
						state_q <= ST_REGS;
					end
				end
				ST_EXT: begin
					if (cnt_q == 3'd4) begin
						cnt_q   <= 3'd0;
						state_q <= ST_EXTL;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_EXTL: state_q <= ST_REGS;
				ST_REGS: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= 3'd0;
						state_q <= ST_ADDR;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_ADDR: begin
					case (stat.opc)
						smc_pkg::OP_LD_OFF,
						smc_pkg::OP_LD_IDX,
						smc_pkg::OP_J_IND,
						smc_pkg::OP_J_IDX:  state_q <= ST_MRD;
						smc_pkg::OP_ST_OFF,
						smc_pkg::OP_ST_IDX: state_q <= ST_MWR;
						default:            state_q <= ST_WB;
					endcase
				end
				ST_MRD: begin
					if (cnt_q == 3'd4) begin
						cnt_q   <= 3'd0;
						state_q <= ST_WB;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_MWR: begin
					if (cnt_q == 3'd3) begin
						cnt_q   <= 3'd0;
						state_q <= ST_WB;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_WB: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/simple_machine_core.sv]
// ----------------------------------------------------------------------------
// simple_machine_core
// Teaching-machine core with eight 32-bit registers and a byte memory of
// big-endian words, driven one operation per input transfer.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries an operation in s_tuser (write byte, read byte,
// read register, restart, step) and its operands in s_tdata. Exactly one
// result transfer follows on the master side with the read value, the pc,
// the halt flag and an error code. The block works on one item at a time:
// s_tready is high only while it is idle.
// A step that is not halted is paced by the single byte-wide memory port,
// which fetches two or six instruction bytes and moves up to four data bytes
// one per cycle, and by the three operand reads from the one register file
// read port.
// A finished result waits in the output register while the next item is
// accepted; a stalled receiver only holds the controller once the next
// result is ready. The user is to write start_pc on the cfg channel only
// while idle; the block itself does not enforce it.
// Reset clears the registers, pc, halt flag and start_pc; memory content is
// undefined until written. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module simple_machine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // mem_address[15:0], write_byte[23:16], reg_select[26:24]
	input  logic [2:0]  s_tuser,   // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // read_value[31:0], program_counter[63:32],
	                               // halted[64], error_code[66:65]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // start_pc[15:0]
);

	smc_pkg::smc_cmd_t  cmd;
	smc_pkg::smc_stat_t stat;
	logic [66:0]        out_data;

	assign cfg_ready = 1'b1;

	smc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_mode (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	smc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_mem_address(s_tdata[15:0]),
		.in_write_byte (s_tdata[23:16]),
		.in_reg_select (s_tdata[26:24]),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.out_data      (out_data)
	);

	assign m_tdata = {5'd0, out_data};

endmodule

[design/smc_chk.sv]
// ----------------------------------------------------------------------------
// smc_chk
// Port-level checks of the simple machine core, bound to the top level.
// ----------------------------------------------------------------------------
module smc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only one item is in work at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// Error codes stay within their defined range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[66:65] != 2'd3)
		else $error("undefined error code");

	// An error comes only from an instruction executed while running.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66:65] != 2'd0 |-> !m_tdata[64])
		else $error("error reported while halted");

endmodule

bind simple_machine_core smc_chk u_chk (.*);

[tb/sv/simple_machine_core_tb.sv]
// ----------------------------------------------------------------------------
// simple_machine_core_tb
// Self-checking testbench for the simple machine core. A predictor of the
// machine runs at each input transfer and queues the expected result; a
// checker compares every result transfer field by field. Before each step
// the predictor works out which bytes the instruction will read, and any
// byte not yet written is written first, so that no unwritten byte is read.
// ----------------------------------------------------------------------------
module simple_machine_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [31:0] read_value;
		logic [31:0] pc;
		logic        halted;
		logic [1:0]  err;
	} machine_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// Machine state as the predictor sees it.
	logic [7:0]  mem_image [smc_pkg::MEM_BYTES];
	bit          byte_written [smc_pkg::MEM_BYTES];
	logic [31:0] gpr [smc_pkg::NUM_REGS];
	logic [31:0] pc_now = '0;
	logic        halt_now = 1'b0;
	logic [15:0] start_addr = '0;

	// Addresses an instruction will read, gathered in a dry run.
	bit          dry_run = 1'b0;
	logic [15:0] read_addrs [$];
	logic [15:0] written_addrs [$];

	machine_result_t results_due [$];
	int          errors = 0;
	int          items_sent = 0;
	int          cycles = 0;
	int          src_idle = 0;
	int          snk_idle = 0;

	simple_machine_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Cycle counter with a hard limit on the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The receiver stalls at random.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Byte read; a dry run only notes the address.
	function automatic logic [7:0] mem_byte(input logic [31:0] a);
		if (dry_run) read_addrs.push_back(a[15:0]);
		return mem_image[a[15:0]];
	endfunction

	function automatic logic [31:0] mem_word(input logic [31:0] a);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < 4; i++) w = {w[23:0], mem_byte(a + i)};
		return w;
	endfunction

	function automatic void store_byte(input logic [15:0] a, input logic [7:0] v);
		if (!byte_written[a]) written_addrs.push_back(a);
		mem_image[a] = v;
		byte_written[a] = 1'b1;
	endfunction

	function automatic void store_word(input logic [31:0] a, input logic [31:0] v);
		if (dry_run) return;
		for (int i = 0; i < 4; i++) store_byte(16'(a + i), v[31 - 8 * i -: 8]);
	endfunction

	function automatic logic [31:0] branch_offset(input logic [7:0] imm);
		return {{23{imm[7]}}, imm, 1'b0};
	endfunction

	// Positive immediates shift left; zero or negative shift right arithmetically.
	function automatic logic [31:0] shifted(input logic [31:0] v, input logic [7:0] imm);
		logic [7:0] count;
		if (imm != 8'd0 && !imm[7]) return (imm >= 8'd32) ? 32'd0 : v << imm;
		count = 8'd0 - imm;
		if (count >= 8'd32) return {32{v[31]}};
		return $signed(v) >>> count;
	endfunction

	// Fetch and execute one instruction; in a dry run nothing is committed.
	function automatic logic [1:0] run_instruction();
		logic [31:0] r [smc_pkg::NUM_REGS];
		logic [31:0] p, ext;
		logic [7:0]  b0, b1;
		logic [3:0]  opc, f0, f1, f2;
		logic [2:0]  r0, r1, r2;
		logic        hlt;
		logic [1:0]  err;
		r = gpr;
		p = pc_now;
		hlt = halt_now;
		err = smc_pkg::ERR_NONE;
		ext = '0;
		b0 = mem_byte(p);
		b1 = mem_byte(p + 1);
		opc = b0[7:4];
		f0 = b0[3:0];
		f1 = b1[7:4];
		f2 = b1[3:0];
		r0 = f0[2:0];
		r1 = f1[2:0];
		r2 = f2[2:0];
		p = p + 2;
		if (opc == smc_pkg::OP_LD_IMM || opc == smc_pkg::OP_J_IMM) begin
			ext = mem_word(p);
			p = p + 4;
		end
		case (opc)
			smc_pkg::OP_LD_IMM: r[r0] = ext;
			smc_pkg::OP_LD_OFF: r[r2] = mem_word(32'(f0) * 4 + r[r1]);
			smc_pkg::OP_LD_IDX: r[r2] = mem_word(r[r0] + r[r1] * 4);
			smc_pkg::OP_ST_OFF: store_word(32'(f1) * 4 + r[r2], r[r0]);
			smc_pkg::OP_ST_IDX: store_word(r[r1] + r[r2] * 4, r[r0]);
			smc_pkg::OP_ALU: begin
				case (f0)
					smc_pkg::ALU_MOV:  r[r2] = r[r1];
					smc_pkg::ALU_ADD:  r[r2] = r[r1] + r[r2];
					smc_pkg::ALU_AND:  r[r2] = r[r1] & r[r2];
					smc_pkg::ALU_INC:  r[r2] = r[r2] + 1;
					smc_pkg::ALU_INC4: r[r2] = r[r2] + 4;
					smc_pkg::ALU_DEC:  r[r2] = r[r2] - 1;
					smc_pkg::ALU_DEC4: r[r2] = r[r2] - 4;
					smc_pkg::ALU_NOT:  r[r2] = ~r[r2];
					smc_pkg::ALU_GPC:  r[r2] = p + 32'(f1) * 2;
					default:           err = smc_pkg::ERR_ALU;
				endcase
			end
			smc_pkg::OP_SHIFT: r[r0] = shifted(r[r0], b1);
			smc_pkg::OP_BR:    p = p + branch_offset(b1);
			smc_pkg::OP_BEQ:   if (r[r0] == 0) p = p + branch_offset(b1);
			smc_pkg::OP_BGT:   if (r[r0] != 0 && !r[r0][31]) p = p + branch_offset(b1);
			smc_pkg::OP_J_IMM: p = ext;
			smc_pkg::OP_J_REG: p = 32'(b1) * 2 + r[r0];
			smc_pkg::OP_J_IND: p = mem_word(r[r0] + 32'(b1) * 4);
			smc_pkg::OP_J_IDX: p = mem_word(r[r0] + r[r1] * 4);
			smc_pkg::OP_HALT_NOP: if (f0 == 4'h0) hlt = 1'b1;
			default:           err = smc_pkg::ERR_OPC;
		endcase
		if (!dry_run && err != smc_pkg::ERR_ALU) begin
			gpr = r;
		end
		if (!dry_run) begin
			pc_now = p;
			halt_now = hlt;
		end
		return err;
	endfunction

	function automatic machine_result_t predict(input logic [2:0] md, input logic [15:0] ad,
			input logic [7:0] wb, input logic [2:0] rs);
		machine_result_t res;
		res.read_value = '0;
		res.err = smc_pkg::ERR_NONE;
		case (md)
			smc_pkg::MODE_WRITE_BYTE: store_byte(ad, wb);
			smc_pkg::MODE_READ_BYTE:  res.read_value = {24'd0, mem_image[ad]};
			smc_pkg::MODE_READ_REG:   res.read_value = gpr[rs];
			smc_pkg::MODE_RESTART: begin
				pc_now = {16'd0, start_addr};
				halt_now = 1'b0;
			end
			smc_pkg::MODE_STEP:       if (!halt_now) res.err = run_instruction();
			default: ;
		endcase
		res.pc = pc_now;
		res.halted = halt_now;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------------

	// Send one item; called and returning at a rising edge.
	task automatic send_item(input logic [2:0] md, input logic [15:0] ad = '0,
			input logic [7:0] wb = '0, input logic [2:0] rs = '0);
		logic acc;
		results_due.push_back(predict(md, ad, wb, rs));
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, rs, wb, ad};
		s_tuser  <= md;
		do begin
			@(negedge clk);
			acc = s_tready;
			@(posedge clk);
		end while (!acc);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// Write start_pc while the block is idle.
	task automatic write_start_pc(input logic [15:0] v);
		logic acc;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		start_addr = v;
	endtask

	// Step once, first writing every byte the instruction would read unwritten.
	task automatic step_once();
		bit filled;
		do begin
			filled = 1'b0;
			if (!halt_now) begin
				read_addrs.delete();
				dry_run = 1'b1;
				void'(run_instruction());
				dry_run = 1'b0;
				foreach (read_addrs[i]) begin
					if (!byte_written[read_addrs[i]]) begin
						send_item(smc_pkg::MODE_WRITE_BYTE, read_addrs[i], 8'($urandom));
						filled = 1'b1;
					end
				end
			end
		end while (filled);
		send_item(smc_pkg::MODE_STEP);
	endtask

	// Place an instruction at the current pc and execute it.
	task automatic exec_instr(input logic [7:0] b0, input logic [7:0] b1,
			input logic [31:0] ext = '0);
		logic [31:0] a;
		a = pc_now;
		send_item(smc_pkg::MODE_WRITE_BYTE, a[15:0], b0);
		send_item(smc_pkg::MODE_WRITE_BYTE, 16'(a + 1), b1);
		if (b0[7:4] == smc_pkg::OP_LD_IMM || b0[7:4] == smc_pkg::OP_J_IMM) begin
			for (int i = 0; i < 4; i++)
				send_item(smc_pkg::MODE_WRITE_BYTE, 16'(a + 2 + i), ext[31 - 8 * i -: 8]);
		end
		step_once();
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	// Check each result transfer against the oldest expectation.
	always @(negedge clk) begin
		machine_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
			end else begin
				want = results_due.pop_front();
				if (m_tdata[31:0] !== want.read_value)
					report_mismatch("read_value", m_tdata[31:0], want.read_value);
				if (m_tdata[63:32] !== want.pc)
					report_mismatch("program_counter", m_tdata[63:32], want.pc);
				if (m_tdata[64] !== want.halted)
					report_mismatch("halted", 32'(m_tdata[64]), 32'(want.halted));
				if (m_tdata[66:65] !== want.err)
					report_mismatch("error_code", 32'(m_tdata[66:65]), 32'(want.err));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Every opcode and ALU function at least once, plus edge cases, starting at pc zero.
	task automatic test_directed();
		send_item(smc_pkg::MODE_WRITE_BYTE, 16'hffff, 8'hff);
		send_item(smc_pkg::MODE_READ_BYTE, 16'hffff);
		send_item(smc_pkg::MODE_READ_REG, 16'h0, 8'h0, 3'd7);
		exec_instr({smc_pkg::OP_LD_IMM, 4'h8}, 8'h00, 32'h8000_0000); // field 8 maps to r0
		exec_instr({smc_pkg::OP_LD_IMM, 4'h1}, 8'h00, 32'h0000_0004);
		exec_instr({smc_pkg::OP_SHIFT, 4'h0}, 8'h80);         // right by 128: sign fill
		exec_instr({smc_pkg::OP_SHIFT, 4'h1}, 8'h1f);
		exec_instr({smc_pkg::OP_SHIFT, 4'h1}, 8'h20);         // left by 32 gives zero
		exec_instr({smc_pkg::OP_SHIFT, 4'h0}, 8'h00);
		for (int f = 0; f < 16; f++) exec_instr({smc_pkg::OP_ALU, 4'(f)}, 8'h12);
		exec_instr({4'h5, 4'h0}, 8'h00);                      // illegal opcode
		exec_instr({smc_pkg::OP_LD_OFF, 4'hf}, 8'h12);
		exec_instr({smc_pkg::OP_LD_IDX, 4'h1}, 8'h23);
		exec_instr({smc_pkg::OP_ST_OFF, 4'h1}, 8'hf2);
		exec_instr({smc_pkg::OP_ST_IDX, 4'h2}, 8'h13);
		exec_instr({smc_pkg::OP_BGT, 4'h0}, 8'h7f);           // negative register
		exec_instr({smc_pkg::OP_BEQ, 4'h1}, 8'h80);
		exec_instr({smc_pkg::OP_BR, 4'h0}, 8'hff);
		exec_instr({smc_pkg::OP_J_REG, 4'h1}, 8'hff);         // unsigned offset
		exec_instr({smc_pkg::OP_J_IND, 4'h1}, 8'hff);
		exec_instr({smc_pkg::OP_J_IDX, 4'h1}, 8'h20);
		exec_instr({smc_pkg::OP_J_IMM, 4'h0}, 8'h00, 32'hffff_fffe);
		exec_instr({smc_pkg::OP_HALT_NOP, 4'h1}, 8'h00);      // nop
		exec_instr({smc_pkg::OP_HALT_NOP, 4'h0}, 8'h00);      // halt
		step_once();                                          // step while halted
		for (int md = 5; md < 8; md++) send_item(3'(md), 16'hffff, 8'hff, 3'd7);
		// Instruction that wraps over the top of memory.
		write_start_pc(16'hfffc);
		send_item(smc_pkg::MODE_RESTART);
		exec_instr({smc_pkg::OP_LD_IMM, 4'h2}, 8'h00, 32'h1234_5678);
		send_item(smc_pkg::MODE_READ_REG, 16'h0, 8'h0, 3'd2);
	endtask

	// Random programs with memory and register traffic mixed in.
	task automatic test_random(input int n_items, input int s_idle, input int r_idle);
		int target, pick;
		logic [3:0] opc;
		target = items_sent + n_items;
		src_idle = s_idle;
		snk_idle = r_idle;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (halt_now && pick < 60) begin
				send_item(smc_pkg::MODE_RESTART);
			end else if (pick < 55) begin
				opc = ($urandom_range(4) == 0) ? smc_pkg::OP_LD_IMM : 4'($urandom);
				exec_instr({opc, 4'($urandom)}, 8'($urandom),
					($urandom_range(1) == 0) ? 32'($urandom_range(255)) : $urandom);
			end else if (pick < 65) begin
				step_once();
			end else if (pick < 75) begin
				send_item(smc_pkg::MODE_WRITE_BYTE, 16'($urandom), 8'($urandom));
			end else if (pick < 83) begin
				send_item(smc_pkg::MODE_READ_BYTE,
					written_addrs[$urandom_range(written_addrs.size() - 1)]);
			end else if (pick < 93) begin
				send_item(smc_pkg::MODE_READ_REG, 16'($urandom), 8'($urandom),
					3'($urandom));
			end else if (pick < 97) begin
				send_item(smc_pkg::MODE_RESTART);
			end else begin
				send_item(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom),
					3'($urandom));
			end
		end
	endtask

	initial begin
		foreach (gpr[i]) gpr[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_start_pc(16'hffff);
		send_item(smc_pkg::MODE_RESTART);
		test_random(430, 9, 83);
		write_start_pc(16'($urandom));
		test_random(430, 83, 9);
		write_start_pc(16'h0000);
		test_random(430, 0, 0);
		wait_drained();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
